// ===== hw/rtl/version_chain_scavenge_inventory_unit_macros.svh =====
// assertion macros shared by the scavenge inventory rtl
// no dependencies
`ifndef VERSION_CHAIN_SCAVENGE_INVENTORY_UNIT_MACROS_SVH
`define VERSION_CHAIN_SCAVENGE_INVENTORY_UNIT_MACROS_SVH
// assert a property under the usual clock and reset
`define VCSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// assert that an event implies a condition in the next cycle
`define VCSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/vcsi_pkg.sv =====
// shared types, constants and helpers for the scavenge inventory unit
// no dependencies
package vcsi_pkg;
  localparam int unsigned AgeGroupCount = 32;
  localparam int unsigned AgeW = $clog2(AgeGroupCount);
  localparam int unsigned MaxChain = 65535;
  localparam logic [15:0] PosLimit = 16'(MaxChain - 1);
  localparam logic [47:0] Max48 = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned InW = 88;
  localparam int unsigned OutW = 136;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    OP_INVENTORY = 2'd0, OP_THRESHOLD = 2'd1, OP_RETIRE = 2'd2, OP_READ = 2'd3
  } op_e;
  typedef enum logic [1:0] {
    CLS_NONE = 2'd0, CLS_PRUNE = 2'd1, CLS_RETIRE = 2'd2
  } cls_e;
  typedef enum logic [1:0] {
    REG_BASE_GEN = 2'd0, REG_SPACE = 2'd1, REG_LOW_MEM = 2'd2
  } reg_e;
  typedef enum logic [1:0] {
    ST_IDLE, ST_HIST, ST_SCAN, ST_OUT
  } st_e;

  // unpacked request passed from front to back
  typedef struct packed {
    op_e         op;
    logic        base;
    logic        last;
    logic        ver;
    logic        cb;
    logic        sole;
    logic        lck;
    logic        prior;
    logic        tref;
    logic [19:0] size;
    logic [47:0] gen;
    logic [5:0]  sel;
  } req_t;

  typedef struct packed {
    logic [47:0] counter_value;
    logic        can_retire;
    logic [47:0] scavenge_generation;
    logic [15:0] oldest_visible_position;
    logic        oldest_visible_valid;
    logic [15:0] chain_position;
    logic [1:0]  record_class;
  } res_t;

  function automatic logic [47:0] sat_add(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? Max48 : s[47:0];
  endfunction
endpackage

// ===== hw/rtl/vcsi_front.sv =====
// front: accepts requests and unpacks them into a two-entry queue
// depends on vcsi_pkg
module vcsi_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [vcsi_pkg::InW-1:0]    s_axis_tdata,
  output logic                        q_valid_o,
  input  logic                        q_pop_i,
  output vcsi_pkg::req_t              q_req_o
);
  import vcsi_pkg::*;
  req_t       mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  req_t       r;
  logic       push;

  always_comb begin
    r.op    = op_e'(s_axis_tdata[1:0]);
    r.base  = s_axis_tdata[2];
    r.last  = s_axis_tdata[3];
    r.ver   = s_axis_tdata[4];
    r.cb    = s_axis_tdata[5];
    r.sole  = s_axis_tdata[6];
    r.lck   = s_axis_tdata[7];
    r.prior = s_axis_tdata[8];
    r.tref  = s_axis_tdata[9];
    r.size  = s_axis_tdata[29:10];
    r.gen   = s_axis_tdata[77:30];
    r.sel   = s_axis_tdata[83:78];
  end

  assign s_axis_tready = (cnt_q != 2'(QDepth));
  assign push = s_axis_tvalid && s_axis_tready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  `include "version_chain_scavenge_inventory_unit_macros.svh"
  `VCSI_ASSERT(a_no_overflow, !(push && cnt_q == 2'(QDepth)), "queue overflow")
  `VCSI_ASSERT(a_no_underflow, !(q_pop_i && cnt_q == 2'd0), "queue underflow")
  `VCSI_ASSERT(a_cnt_range, cnt_q <= 2'(QDepth), "queue count out of range")
endmodule

// ===== hw/rtl/vcsi_back.sv =====
// back: executes requests, holds counters, histogram and chain state
// depends on vcsi_pkg
module vcsi_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  output logic                        q_pop_o,
  input  vcsi_pkg::req_t              q_req_i,
  input  logic [47:0]                 base_gen_i,
  input  logic [47:0]                 space_i,
  input  logic                        low_mem_i,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [vcsi_pkg::OutW-1:0]   m_axis_tdata
);
  import vcsi_pkg::*;
  st_e st_q, st_d;
  logic [47:0] age_q [AgeGroupCount];
  logic [47:0] cls_q [8];
  logic [47:0] tot_cnt_q, tot_sp_q, vo_cnt_q, vo_sp_q, thr_q;
  logic [15:0] longest_q, pos_q, opos_q;
  logic        ofound_q;
  res_t        res_q;
  logic        ovalid_q;
  req_t        cur_q;
  logic [AgeW-1:0] hidx_q, sidx_q;
  logic        hist_en_q, vo_en_q;
  logic [47:0] run_q;

  // inventory classification (combinational from queue head)
  logic [15:0] pos_c;
  logic        of_c, of_n;
  logic [15:0] op_n;
  cls_e        cls_c;
  logic [47:0] diff;
  logic        older;
  always_comb begin
    pos_c = q_req_i.base ? 16'd0 : pos_q;
    of_c  = q_req_i.base ? 1'b0 : ofound_q;
    op_n  = q_req_i.base ? 16'd0 : opos_q;
    of_n  = of_c;
    cls_c = CLS_NONE;
    if (!q_req_i.ver) begin
      if (q_req_i.base) cls_c = CLS_RETIRE;
      else if (of_c) cls_c = CLS_PRUNE;
      else begin of_n = 1'b1; op_n = pos_c; end
    end else begin
      if (q_req_i.base && q_req_i.cb) cls_c = CLS_RETIRE;
      if (of_c) begin
        if (!q_req_i.cb || !q_req_i.sole) of_n = 1'b0;
        else cls_c = CLS_PRUNE;
      end else if (q_req_i.cb && !q_req_i.lck) begin
        of_n = 1'b1; op_n = pos_c;
      end
    end
    diff  = base_gen_i - q_req_i.gen;
    older = q_req_i.gen < base_gen_i;
  end

  // threshold candidate for current scan index
  logic [47:0] run_n;
  logic        hit;
  logic [47:0] cand;
  logic        scan_done;
  logic [47:0] scan_gen;
  always_comb begin
    run_n = sat_add(run_q, age_q[sidx_q]);
    hit   = run_n >= space_i;
    cand  = (base_gen_i > 48'(sidx_q)) ? base_gen_i - 48'(sidx_q) : 48'd0;
    // a hit whose generation clamps to zero means none, so the scan goes on
    scan_done = (hit && cand != 48'd0) || sidx_q == AgeW'(1);
    scan_gen  = (hit && cand != 48'd0) ? cand : 48'd0;
  end

  logic [47:0] rd;
  always_comb begin
    rd = 48'd0;
    if (cur_q.sel == 6'd0) rd = tot_cnt_q;
    else if (cur_q.sel == 6'd1) rd = tot_sp_q;
    else if (cur_q.sel <= 6'd7) rd = cls_q[3'(cur_q.sel - 6'd2)];
    else if (cur_q.sel == 6'd8) rd = vo_cnt_q;
    else if (cur_q.sel == 6'd9) rd = vo_sp_q;
    else if (cur_q.sel == 6'd10) rd = {32'd0, longest_q};
    else if (7'(cur_q.sel) - 7'd11 < 7'(AgeGroupCount))
      rd = age_q[AgeW'(cur_q.sel - 6'd11)];
  end

  // result words for each kind of request
  res_t inv_res, scan_res, out_res;
  always_comb begin
    inv_res = '0;
    inv_res.record_class   = cls_c;
    inv_res.chain_position = pos_c;
    if (q_req_i.last) begin
      inv_res.oldest_visible_valid    = of_n;
      inv_res.oldest_visible_position = of_n ? op_n : 16'd0;
    end
    scan_res = '0;
    scan_res.scavenge_generation = scan_gen;
    out_res = '0;
    if (cur_q.op == OP_THRESHOLD) out_res.scavenge_generation = thr_q;
    else if (cur_q.op == OP_RETIRE)
      out_res.can_retire = (cur_q.gen <= thr_q) && (!cur_q.ver ||
        (cur_q.sole && !cur_q.prior && cur_q.cb && !cur_q.tref));
    else out_res.counter_value = rd;
  end

  logic take;
  always_comb begin
    st_d = st_q;
    take = 1'b0;
    case (st_q)
      ST_IDLE: if (q_valid_i && !ovalid_q) begin
        take = 1'b1;
        st_d = (q_req_i.op == OP_INVENTORY) ? ST_HIST :
               (q_req_i.op == OP_THRESHOLD && !low_mem_i) ? ST_SCAN : ST_OUT;
      end
      ST_HIST: st_d = ST_IDLE;
      ST_SCAN: if (scan_done) st_d = ST_IDLE;
      ST_OUT:  st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end
  assign q_pop_o = take;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = OutW'(res_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; ovalid_q <= 1'b0;
      for (int i = 0; i < AgeGroupCount; i++) age_q[i] <= 48'd0;
      for (int i = 0; i < 8; i++) cls_q[i] <= 48'd0;
      tot_cnt_q <= '0; tot_sp_q <= '0; vo_cnt_q <= '0; vo_sp_q <= '0;
      thr_q <= '0; longest_q <= '0; pos_q <= '0; opos_q <= '0; ofound_q <= 1'b0;
      hist_en_q <= 1'b0; vo_en_q <= 1'b0; hidx_q <= '0; sidx_q <= '0;
      run_q <= '0; cur_q <= '0; res_q <= '0;
    end else begin
      st_q <= st_d;
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      if (take) begin
        cur_q <= q_req_i;
        if (q_req_i.op == OP_INVENTORY) begin
          if (pos_c + 16'd1 > longest_q) longest_q <= pos_c + 16'd1;
          tot_cnt_q <= sat_add(tot_cnt_q, 48'd1);
          tot_sp_q  <= sat_add(tot_sp_q, 48'(q_req_i.size));
          cls_q[{cls_c, 1'b0}] <= sat_add(cls_q[{cls_c, 1'b0}], 48'd1);
          cls_q[{cls_c, 1'b1}] <= sat_add(cls_q[{cls_c, 1'b1}], 48'(q_req_i.size));
          hist_en_q <= q_req_i.base && (!older || diff < 48'(AgeGroupCount));
          vo_en_q   <= q_req_i.base && older && diff >= 48'(AgeGroupCount);
          hidx_q    <= older ? AgeW'(diff) : '0;
          res_q <= inv_res;
          if (q_req_i.last) begin
            pos_q <= '0; ofound_q <= 1'b0; opos_q <= '0;
          end else begin
            pos_q <= (pos_c < PosLimit) ? pos_c + 16'd1 : pos_c;
            ofound_q <= of_n; opos_q <= op_n;
          end
        end else if (q_req_i.op == OP_THRESHOLD) begin
          run_q <= vo_sp_q;
          sidx_q <= AgeW'(AgeGroupCount - 1);
          if (low_mem_i) thr_q <= base_gen_i;
        end
      end
      case (st_q)
        ST_HIST: begin
          if (hist_en_q) age_q[hidx_q] <= sat_add(age_q[hidx_q], 48'(cur_q.size));
          if (vo_en_q) begin
            vo_cnt_q <= sat_add(vo_cnt_q, 48'd1);
            vo_sp_q  <= sat_add(vo_sp_q, 48'(cur_q.size));
          end
          ovalid_q <= 1'b1;
        end
        ST_SCAN: begin
          run_q <= run_n;
          sidx_q <= sidx_q - AgeW'(1);
          if (scan_done) begin
            thr_q <= scan_gen;
            res_q <= scan_res;
            ovalid_q <= 1'b1;
          end
        end
        ST_OUT: begin
          res_q <= out_res;
          ovalid_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  `include "version_chain_scavenge_inventory_unit_macros.svh"
  `VCSI_ASSERT(a_take_idle, !take || (st_q == ST_IDLE && !ovalid_q), "take while busy")
  `VCSI_ASSERT_NEXT(a_hist_out, st_q == ST_HIST, ovalid_q, "inventory result lost")
  `VCSI_ASSERT(a_busy_no_out, !(ovalid_q && st_q != ST_IDLE), "output while busy")
endmodule

// ===== hw/rtl/version_chain_scavenge_inventory_unit.sv =====
// top level of the version chain scavenge inventory unit
// depends on vcsi_pkg, vcsi_front, vcsi_back
//
// channel   | dir | content
// s_axis    | in  | one request: op and record fields
// m_axis    | out | one result per request
// cfg       | in  | register write, index 0..2
//
// front queue holds two requests; back takes one when its result register is empty
// inventory: classify on take, then histogram read-modify-write with the result,
// then the result handshake before the next take; other ops likewise
// threshold scan: one age group a cycle oldest first, then the result handshake
// all counters and the histogram clear at reset, no clearing pass
// a stalled result holds in the output register; the front keeps queueing meanwhile
module version_chain_scavenge_inventory_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // op, first_in_chain, last_in_chain, is_version, committed_before, sole_user,
  // locked, has_prior, has_txn_reference, record_size, record_generation,
  // counter_select, zero fill
  input  logic [vcsi_pkg::InW-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // record_class, chain_position, oldest_visible_valid, oldest_visible_position,
  // scavenge_generation, can_retire, counter_value, zero fill
  output logic [vcsi_pkg::OutW-1:0] m_axis_tdata,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [47:0]               cfg_data_i
);
  import vcsi_pkg::*;
  logic [47:0] base_q, space_q;
  logic        low_q;
  logic        qv, pop;
  req_t        qr;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0; space_q <= '0; low_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_BASE_GEN: base_q <= cfg_data_i;
        REG_SPACE:    space_q <= cfg_data_i;
        REG_LOW_MEM:  low_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  vcsi_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .q_valid_o(qv), .q_pop_i(pop), .q_req_o(qr)
  );

  vcsi_back u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_pop_o(pop), .q_req_i(qr),
    .base_gen_i(base_q), .space_i(space_q), .low_mem_i(low_q),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );
endmodule

// ===== verif/version_chain_scavenge_inventory_unit_tb.sv =====
// self-checking testbench for the version chain scavenge inventory unit
// drives requests over the stream slave, checks every result against a local predictor or a typed-in result
// depends on vcsi_pkg and version_chain_scavenge_inventory_unit
module version_chain_scavenge_inventory_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vcsi_pkg::*;

  localparam int unsigned NumGroups = 32;
  localparam logic [47:0] Ones48 = 48'hFFFF_FFFF_FFFF;

  // one request as the block sees it
  typedef struct {
    op_e         op;
    bit          base;
    bit          last;
    bit          ver;
    bit          cb;
    bit          sole;
    bit          lck;
    bit          prior;
    bit          tref;
    logic [19:0] size;
    logic [47:0] gen;
    logic [5:0]  sel;
  } request_t;

  // directed row: request plus an optional typed-in result
  typedef struct {
    request_t req;
    bit       typed;
    res_t     res;
  } row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic            cfg_we_i = 1'b0;
  logic [1:0]      cfg_index_i = '0;
  logic [47:0]     cfg_data_i = '0;

  version_chain_scavenge_inventory_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  // predictor copy of configuration and state
  logic [47:0] cfg_base_gen, cfg_space_goal;
  bit          cfg_low_mem;
  logic [47:0] hist_space [NumGroups];
  logic [47:0] class_tally [8];
  logic [47:0] rec_count, rec_space, old_count, old_space, scav_gen;
  logic [15:0] max_chain_len, next_pos, visible_pos;
  bit          visible_seen;

  res_t results_due [$];
  int   fail_count = 0;
  int   sent_count = 0;
  int   seen_count = 0;
  int   op_seen [4] = '{0, 0, 0, 0};
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("version_chain_scavenge_inventory_unit_tb: errors");
    $finish;
  end

  function automatic logic [47:0] add_sat(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? Ones48 : s[47:0];
  endfunction

  function automatic logic [InW-1:0] pack_request(input request_t r);
    logic [InW-1:0] d;
    d = '0;
    d[83:0] = {r.sel, r.gen, r.size, r.tref, r.prior, r.lck, r.sole, r.cb, r.ver,
               r.last, r.base, r.op};
    return d;
  endfunction

  task automatic clear_model();
    cfg_base_gen = '0; cfg_space_goal = '0; cfg_low_mem = 0;
    foreach (hist_space[i]) hist_space[i] = '0;
    foreach (class_tally[i]) class_tally[i] = '0;
    rec_count = '0; rec_space = '0; old_count = '0; old_space = '0; scav_gen = '0;
    max_chain_len = '0; next_pos = '0; visible_pos = '0; visible_seen = 0;
  endtask

  // advances the predictor by one request and returns the result it implies
  function automatic res_t classify_and_tally(input request_t r);
    res_t        o;
    logic [15:0] pos;
    logic [47:0] age, total;
    cls_e        cls;
    int          n;
    o = '0;
    case (r.op)
      OP_INVENTORY: begin
        cls = CLS_NONE;
        if (r.base) begin
          next_pos = '0; visible_seen = 0; visible_pos = '0;
        end
        pos = next_pos;
        if ({1'b0, pos} + 17'd1 > {1'b0, max_chain_len}) max_chain_len = pos + 16'd1;
        if (next_pos < PosLimit) next_pos++;
        rec_count = add_sat(rec_count, 48'd1);
        rec_space = add_sat(rec_space, 48'(r.size));
        if (!r.ver) begin
          if (r.base) cls = CLS_RETIRE;
          else if (visible_seen) cls = CLS_PRUNE;
          else begin
            visible_seen = 1; visible_pos = pos;
          end
        end else begin
          if (r.base && r.cb) cls = CLS_RETIRE;
          if (visible_seen) begin
            if (!r.cb || !r.sole) visible_seen = 0;
            else cls = CLS_PRUNE;
          end else if (r.cb && !r.lck) begin
            visible_seen = 1; visible_pos = pos;
          end
        end
        class_tally[2*cls] = add_sat(class_tally[2*cls], 48'd1);
        class_tally[2*cls+1] = add_sat(class_tally[2*cls+1], 48'(r.size));
        if (r.base) begin
          if (r.gen >= cfg_base_gen) hist_space[0] = add_sat(hist_space[0], 48'(r.size));
          else begin
            age = cfg_base_gen - r.gen;
            if (age < NumGroups) hist_space[age] = add_sat(hist_space[age], 48'(r.size));
            else begin
              old_count = add_sat(old_count, 48'd1);
              old_space = add_sat(old_space, 48'(r.size));
            end
          end
        end
        o.record_class = cls;
        o.chain_position = pos;
        if (r.last) begin
          o.oldest_visible_valid = visible_seen;
          o.oldest_visible_position = visible_seen ? visible_pos : '0;
          next_pos = '0; visible_seen = 0; visible_pos = '0;
        end
      end
      OP_THRESHOLD: begin
        scav_gen = '0;
        if (cfg_low_mem) scav_gen = cfg_base_gen;
        else begin
          total = old_space;
          // oldest group first, age 0 never joins the sum
          for (n = NumGroups - 1; n > 0 && scav_gen == '0; n--) begin
            total = add_sat(total, hist_space[n]);
            if (total >= cfg_space_goal)
              scav_gen = (cfg_base_gen > n) ? cfg_base_gen - 48'(n) : '0;
          end
        end
        o.scavenge_generation = scav_gen;
      end
      OP_RETIRE: begin
        if (r.gen <= scav_gen)
          o.can_retire = !r.ver || (r.sole && !r.prior && r.cb && !r.tref);
      end
      default: begin
        if (r.sel == 0) o.counter_value = rec_count;
        else if (r.sel == 1) o.counter_value = rec_space;
        else if (r.sel <= 7) o.counter_value = class_tally[r.sel - 2];
        else if (r.sel == 8) o.counter_value = old_count;
        else if (r.sel == 9) o.counter_value = old_space;
        else if (r.sel == 10) o.counter_value = 48'(max_chain_len);
        else if (r.sel - 11 < NumGroups) o.counter_value = hist_space[r.sel - 11];
        else o.counter_value = '0;
      end
    endcase
    return o;
  endfunction

  // offers one request with random sender gaps; records the result it must produce
  // valid stays up after acceptance until the next request or a drain
  task automatic send_request(input request_t r, input bit typed, input res_t typed_res);
    res_t p;
    @(negedge clk_i);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = pack_request(r);
    do @(posedge clk_i); while (!s_axis_tready);
    p = classify_and_tally(r);
    results_due.push_back(typed ? typed_res : p);
    sent_count++;
    op_seen[r.op]++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_index_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_BASE_GEN: cfg_base_gen = val;
      REG_SPACE:    cfg_space_goal = val;
      default:      cfg_low_mem = val[0];
    endcase
  endtask

  // receiver: random stalls plus a counted hold-off on request
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker, field by field against the oldest expectation
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
      seen_count++;
      if (results_due.size() == 0) begin
        $error("result with nothing outstanding: %h", got);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (got.record_class !== want.record_class) begin
          $error("record_class exp %0d got %0d", want.record_class, got.record_class);
          fail_count++;
        end
        if (got.chain_position !== want.chain_position) begin
          $error("chain_position exp %0d got %0d", want.chain_position, got.chain_position);
          fail_count++;
        end
        if (got.oldest_visible_valid !== want.oldest_visible_valid) begin
          $error("oldest_visible_valid exp %0d got %0d", want.oldest_visible_valid,
                 got.oldest_visible_valid);
          fail_count++;
        end
        if (got.oldest_visible_position !== want.oldest_visible_position) begin
          $error("oldest_visible_position exp %0d got %0d", want.oldest_visible_position,
                 got.oldest_visible_position);
          fail_count++;
        end
        if (got.scavenge_generation !== want.scavenge_generation) begin
          $error("scavenge_generation exp %0d got %0d", want.scavenge_generation,
                 got.scavenge_generation);
          fail_count++;
        end
        if (got.can_retire !== want.can_retire) begin
          $error("can_retire exp %0d got %0d", want.can_retire, got.can_retire);
          fail_count++;
        end
        if (got.counter_value !== want.counter_value) begin
          $error("counter_value exp %0d got %0d", want.counter_value, got.counter_value);
          fail_count++;
        end
      end
    end
  end

  function automatic request_t make_req(input op_e op, input bit base, input bit last,
                                        input bit ver, input bit cb, input bit sole,
                                        input bit lck, input logic [19:0] size,
                                        input logic [47:0] gen, input logic [5:0] sel);
    request_t r;
    r.op = op; r.base = base; r.last = last; r.ver = ver; r.cb = cb; r.sole = sole;
    r.lck = lck; r.prior = 0; r.tref = 0; r.size = size; r.gen = gen; r.sel = sel;
    return r;
  endfunction

  // random request; chains mostly well formed, generations near the base
  function automatic request_t random_req(input bit base, input bit last);
    request_t r;
    int unsigned pick;
    pick = $urandom_range(99);
    r.op = pick < 62 ? OP_INVENTORY : pick < 72 ? OP_THRESHOLD : pick < 86 ? OP_RETIRE
         : OP_READ;
    r.base = ($urandom_range(19) == 0) ? ~base : base;
    r.last = ($urandom_range(19) == 0) ? ~last : last;
    {r.ver, r.cb, r.sole, r.lck, r.prior, r.tref} = 6'($urandom);
    r.size = ($urandom_range(9) == 0) ? 20'hFFFFF : 20'($urandom_range(4095));
    if ($urandom_range(9) == 0) r.size = 20'($urandom);
    case ($urandom_range(9))
      0:       r.gen = {16'($urandom), 32'($urandom)};
      1:       r.gen = cfg_base_gen + 48'($urandom_range(5));
      default: r.gen = cfg_base_gen - 48'($urandom_range(40));
    endcase
    if (r.op == OP_RETIRE && $urandom_range(1)) r.gen = scav_gen - 48'($urandom_range(2));
    r.sel = 6'($urandom_range(63));
    if ($urandom_range(2) == 0) r.sel = 6'($urandom_range(42));
    return r;
  endfunction

  task automatic random_run(input int count);
    int          left;
    int          len;
    int          i;
    request_t    r;
    left = count;
    while (left > 0) begin
      // an occasional long chain to stretch the longest-chain counter
      len = ($urandom_range(15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
      for (i = 0; i < len && left > 0; i++) begin
        r = random_req(i == 0, i == len - 1);
        send_request(r, 0, '0);
        left--;
      end
    end
  endtask

  row_t table_rows [$];
  res_t zero_res;

  initial begin
    row_t row;
    clear_model();
    zero_res = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows, reset configuration
    row = '{make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 6'd0), 1, zero_res};
    table_rows.push_back(row);
    row = '{make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 6'd42), 1, zero_res};
    table_rows.push_back(row);
    row = '{make_req(OP_THRESHOLD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_res};
    table_rows.push_back(row);
    row.req = make_req(OP_RETIRE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    row.typed = 1; row.res = '0; row.res.can_retire = 1;
    table_rows.push_back(row);
    // chain start without base flag, then disk records
    table_rows.push_back('{make_req(OP_INVENTORY, 0, 0, 0, 0, 0, 0, 20'h0, 48'd0, 0), 0, '0});
    table_rows.push_back('{make_req(OP_INVENTORY, 0, 1, 0, 0, 0, 0, 20'hFFFFF, 0, 0), 0, '0});
    // base disk record with a future generation, then versions
    table_rows.push_back('{make_req(OP_INVENTORY, 1, 0, 0, 1, 1, 0, 20'd77, Ones48, 0), 0,
                           '0});
    table_rows.push_back('{make_req(OP_INVENTORY, 0, 0, 1, 1, 0, 1, 20'd5, 0, 0), 0, '0});
    table_rows.push_back('{make_req(OP_INVENTORY, 0, 0, 1, 1, 1, 0, 20'd6, 0, 0), 0, '0});
    table_rows.push_back('{make_req(OP_INVENTORY, 0, 0, 1, 1, 1, 0, 20'd7, 0, 0), 0, '0});
    // base flag in the middle of a chain
    table_rows.push_back('{make_req(OP_INVENTORY, 1, 0, 1, 1, 1, 0, 20'd8, 0, 0), 0, '0});
    table_rows.push_back('{make_req(OP_INVENTORY, 0, 0, 1, 0, 1, 0, 20'd9, 0, 0), 0, '0});
    table_rows.push_back('{make_req(OP_INVENTORY, 0, 1, 1, 1, 0, 0, 20'd10, 0, 0), 0, '0});
    table_rows.push_back('{make_req(OP_INVENTORY, 1, 1, 1, 0, 0, 0, 20'd11, 0, 0), 0, '0});
    table_rows.push_back('{make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 6'd10), 0, '0});
    table_rows.push_back('{make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 6'd11), 0, '0});
    table_rows.push_back('{make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 6'd63), 0, '0});
    table_rows.push_back('{make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 6'd5), 0, '0});
    foreach (table_rows[i]) send_request(table_rows[i].req, table_rows[i].typed,
                                         table_rows[i].res);
    drain();

    // phase: small base, modest goal, no idling, with a long receiver hold-off
    write_reg(REG_BASE_GEN, 48'd100);
    write_reg(REG_SPACE, 48'd20000);
    write_reg(REG_LOW_MEM, 48'd0);
    idle_pct = 0; stall_pct = 0;
    hold_cycles = 300;
    random_run(140);
    drain();

    // phase: base zero, maximal goal, sender idles
    write_reg(REG_BASE_GEN, 48'd0);
    write_reg(REG_SPACE, Ones48);
    idle_pct = 55; stall_pct = 0;
    random_run(130);
    drain();

    // phase: maximal base, low memory, receiver stalls
    write_reg(REG_BASE_GEN, Ones48);
    write_reg(REG_SPACE, 48'd0);
    write_reg(REG_LOW_MEM, 48'd1);
    idle_pct = 0; stall_pct = 55;
    random_run(130);
    drain();

    // phase: random base, small goal, both sides idle now and then
    write_reg(REG_BASE_GEN, {16'($urandom), 32'($urandom)});
    write_reg(REG_SPACE, 48'($urandom_range(3000)));
    write_reg(REG_LOW_MEM, 48'd0);
    idle_pct = 9; stall_pct = 9;
    random_run(130);
    drain();

    $display("covered %0d requests (%0d inventory, %0d threshold, %0d retire, %0d read)",
             sent_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("checked %0d results over five configuration settings", seen_count);
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("version_chain_scavenge_inventory_unit_tb: clean");
    end else begin
      $display("version_chain_scavenge_inventory_unit_tb: errors");
    end
    $finish;
  end
endmodule
